### hw/rtl/assert_macros.svh
// Assertion macros used by the top level of the console writer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/tcw_pkg.sv
// Types and constants shared by the text console writer modules.
package tcw_pkg;

    localparam int OP_W        = 3;
    localparam int CHAR_W      = 8;
    localparam int ATTR_W      = 8;
    localparam int IDX_W       = 11;
    localparam int CELL_W      = CHAR_W + ATTR_W;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 3'd0,
        OP_CLEAR = 3'd1,
        OP_LEFT  = 3'd2,
        OP_RIGHT = 3'd3,
        OP_UP    = 3'd4,
        OP_DOWN  = 3'd5,
        OP_READ  = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_READ_WAIT,
        ST_SCROLL_RD,
        ST_SCROLL_WR,
        ST_FILL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
        logic rd_take;
        logic copy_rd;
        logic copy_wr;
        logic fill_step;
        logic init_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic need_scroll;
        logic rd_hit;
        logic sweep_last;
        logic fill_last;
    } t_dp_status;

endpackage

### hw/rtl/tcw_datapath.sv
// Datapath of the text console writer: screen store, cursor, sweep counter and result registers.
module tcw_datapath #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tcw_pkg::t_dp_cmd             i_cmd,
    output tcw_pkg::t_dp_status          o_status,
    input  logic [tcw_pkg::OP_W-1:0]     i_op,
    input  logic [tcw_pkg::CHAR_W-1:0]   i_char,
    input  logic [tcw_pkg::IDX_W-1:0]    i_addr,
    input  logic                         i_cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0]   i_cfg_data,
    output logic [tcw_pkg::IDX_W-1:0]    o_cursor,
    output logic [tcw_pkg::CHAR_W-1:0]   o_cell_char,
    output logic [tcw_pkg::ATTR_W-1:0]   o_cell_attr,
    output logic                         o_scrolled
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int AXW   = ((AW > tcw_pkg::IDX_W) ? AW : tcw_pkg::IDX_W) + 1;

    logic [tcw_pkg::CELL_W-1:0] mem [CELLS];

    logic [tcw_pkg::OP_W-1:0]   r_op;
    logic [tcw_pkg::CHAR_W-1:0] r_char;
    logic [tcw_pkg::IDX_W-1:0]  r_addr;
    logic [tcw_pkg::ATTR_W-1:0] r_attr;
    logic [AW-1:0]              r_cur_idx, n_cur_idx;
    logic [RW-1:0]              r_cur_row, n_cur_row;
    logic [CW-1:0]              r_cur_col, n_cur_col;
    logic [AW-1:0]              r_sweep;
    logic [tcw_pkg::CELL_W-1:0] r_rdata;
    logic [tcw_pkg::CHAR_W-1:0] r_res_char;
    logic [tcw_pkg::ATTR_W-1:0] r_res_attr;
    logic                       r_res_scrolled;
    logic [tcw_pkg::IDX_W-1:0]  r_out_cursor;
    logic [tcw_pkg::CHAR_W-1:0] r_out_char;
    logic [tcw_pkg::ATTR_W-1:0] r_out_attr;
    logic                       r_out_scrolled;

    tcw_pkg::t_op               w_op;
    logic [AXW-1:0]             w_addr_ext;
    logic [AXW-1:0]             w_cur_ext;
    logic                       w_is_nl, w_is_bs;
    logic                       w_at_zero, w_at_last_cell, w_at_last_row, w_at_last_col;
    logic                       w_rd_hit, w_need_scroll;
    logic [tcw_pkg::CELL_W-1:0] w_blank;
    logic                       w_we, w_re;
    logic [AW-1:0]              w_wa, w_ra;
    logic [tcw_pkg::CELL_W-1:0] w_wd;

    assign w_op           = tcw_pkg::t_op'(r_op);
    assign w_addr_ext     = AXW'(r_addr);
    assign w_cur_ext      = AXW'(r_cur_idx);
    assign w_is_nl        = (r_char == tcw_pkg::CH_NEWLINE);
    assign w_is_bs        = (r_char == tcw_pkg::CH_BACKSPACE);
    assign w_at_zero      = (r_cur_idx == '0);
    assign w_at_last_cell = (r_cur_idx == AW'(CELLS - 1));
    assign w_at_last_row  = (r_cur_row == RW'(ROWS - 1));
    assign w_at_last_col  = (r_cur_col == CW'(COLUMNS - 1));
    assign w_rd_hit       = (w_addr_ext < AXW'(CELLS));
    assign w_blank        = {r_attr, tcw_pkg::CH_SPACE};

    // A put that runs off the bottom of the screen needs a scroll.
    assign w_need_scroll  = (w_op == tcw_pkg::OP_PUT) &&
                            (w_is_nl ? w_at_last_row : (!w_is_bs && w_at_last_cell));

    assign o_status.op          = w_op;
    assign o_status.need_scroll = w_need_scroll;
    assign o_status.rd_hit      = w_rd_hit;
    assign o_status.sweep_last  = (r_sweep == AW'(CELLS - COLUMNS - 1));
    assign o_status.fill_last   = (r_sweep == AW'(CELLS - 1));

    // Memory port selection.
    always_comb begin
        w_we = 1'b0;
        w_wa = r_sweep;
        w_wd = w_blank;
        w_re = 1'b0;
        w_ra = r_sweep;
        if (i_cmd.init_step) begin
            w_we = 1'b1;
            w_wd = {{tcw_pkg::ATTR_W{1'b0}}, tcw_pkg::CH_SPACE};
        end
        if (i_cmd.fill_step) begin
            w_we = 1'b1;
        end
        if (i_cmd.copy_rd) begin
            w_re = 1'b1;
            w_ra = r_sweep + AW'(COLUMNS);
        end
        if (i_cmd.copy_wr) begin
            w_we = 1'b1;
            w_wd = r_rdata;
        end
        if (i_cmd.exec) begin
            case (w_op)
                tcw_pkg::OP_PUT: begin
                    if (w_is_bs) begin
                        w_we = !w_at_zero;
                        w_wa = r_cur_idx - AW'(1);
                    end else if (!w_is_nl) begin
                        w_we = 1'b1;
                        w_wa = r_cur_idx;
                        w_wd = {r_attr, r_char};
                    end
                end
                tcw_pkg::OP_READ: begin
                    w_re = w_rd_hit;
                    w_ra = w_addr_ext[AW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
        end
        if (w_re) begin
            r_rdata <= mem[w_ra];
        end
    end

    // Cursor next value; row and column are tracked beside the index.
    always_comb begin
        n_cur_idx = r_cur_idx;
        n_cur_row = r_cur_row;
        n_cur_col = r_cur_col;
        if (i_cmd.exec) begin
            case (w_op)
                tcw_pkg::OP_PUT: begin
                    if (w_need_scroll) begin
                        n_cur_idx = AW'(CELLS - COLUMNS);
                        n_cur_row = RW'(ROWS - 1);
                        n_cur_col = '0;
                    end else if (w_is_nl) begin
                        n_cur_idx = r_cur_idx - AW'(r_cur_col) + AW'(COLUMNS);
                        n_cur_row = r_cur_row + RW'(1);
                        n_cur_col = '0;
                    end else if (w_is_bs) begin
                        if (!w_at_zero) begin
                            n_cur_idx = r_cur_idx - AW'(1);
                            n_cur_col = (r_cur_col == '0) ? CW'(COLUMNS - 1) : r_cur_col - CW'(1);
                            n_cur_row = (r_cur_col == '0) ? r_cur_row - RW'(1) : r_cur_row;
                        end
                    end else begin
                        n_cur_idx = r_cur_idx + AW'(1);
                        n_cur_col = w_at_last_col ? '0 : r_cur_col + CW'(1);
                        n_cur_row = w_at_last_col ? r_cur_row + RW'(1) : r_cur_row;
                    end
                end
                tcw_pkg::OP_CLEAR: begin
                    n_cur_idx = '0;
                    n_cur_row = '0;
                    n_cur_col = '0;
                end
                tcw_pkg::OP_LEFT: begin
                    if (!w_at_zero) begin
                        n_cur_idx = r_cur_idx - AW'(1);
                        n_cur_col = (r_cur_col == '0) ? CW'(COLUMNS - 1) : r_cur_col - CW'(1);
                        n_cur_row = (r_cur_col == '0) ? r_cur_row - RW'(1) : r_cur_row;
                    end
                end
                tcw_pkg::OP_RIGHT: begin
                    if (!w_at_last_cell) begin
                        n_cur_idx = r_cur_idx + AW'(1);
                        n_cur_col = w_at_last_col ? '0 : r_cur_col + CW'(1);
                        n_cur_row = w_at_last_col ? r_cur_row + RW'(1) : r_cur_row;
                    end
                end
                tcw_pkg::OP_UP: begin
                    if (r_cur_row != '0) begin
                        n_cur_idx = r_cur_idx - AW'(COLUMNS);
                        n_cur_row = r_cur_row - RW'(1);
                    end
                end
                tcw_pkg::OP_DOWN: begin
                    if (!w_at_last_row) begin
                        n_cur_idx = r_cur_idx + AW'(COLUMNS);
                        n_cur_row = r_cur_row + RW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr    <= '0;
            r_cur_idx <= '0;
            r_cur_row <= '0;
            r_cur_col <= '0;
            r_sweep   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_attr <= i_cfg_data;
            end
            r_cur_idx <= n_cur_idx;
            r_cur_row <= n_cur_row;
            r_cur_col <= n_cur_col;
            if (i_cmd.exec) begin
                r_sweep <= '0;
            end else if (i_cmd.copy_wr || i_cmd.fill_step || i_cmd.init_step) begin
                r_sweep <= r_sweep + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op           <= i_op;
            r_char         <= i_char;
            r_addr         <= i_addr;
            r_res_char     <= '0;
            r_res_attr     <= '0;
            r_res_scrolled <= 1'b0;
        end
        if (i_cmd.exec && w_need_scroll) begin
            r_res_scrolled <= 1'b1;
        end
        if (i_cmd.rd_take) begin
            r_res_char <= r_rdata[tcw_pkg::CHAR_W-1:0];
            r_res_attr <= r_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
        end
        if (i_cmd.load_out) begin
            r_out_cursor   <= w_cur_ext[tcw_pkg::IDX_W-1:0];
            r_out_char     <= r_res_char;
            r_out_attr     <= r_res_attr;
            r_out_scrolled <= r_res_scrolled;
        end
    end

    assign o_cursor    = r_out_cursor;
    assign o_cell_char = r_out_char;
    assign o_cell_attr = r_out_attr;
    assign o_scrolled  = r_out_scrolled;

endmodule

### hw/rtl/tcw_ctrl.sv
// Controller state machine of the text console writer.
module tcw_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  tcw_pkg::t_dp_status i_status,
    output tcw_pkg::t_dp_cmd    o_cmd
);

    tcw_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcw_pkg::ST_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            tcw_pkg::ST_INIT: begin
                o_cmd.init_step = 1'b1;
                if (i_status.fill_last) begin
                    n_state = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = tcw_pkg::ST_EXEC;
                end
            end
            tcw_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_status.op == tcw_pkg::OP_CLEAR) begin
                    n_state = tcw_pkg::ST_FILL;
                end else if (i_status.op == tcw_pkg::OP_READ && i_status.rd_hit) begin
                    n_state = tcw_pkg::ST_READ_WAIT;
                end else if (i_status.need_scroll) begin
                    n_state = tcw_pkg::ST_SCROLL_RD;
                end else begin
                    n_state = tcw_pkg::ST_DONE;
                end
            end
            tcw_pkg::ST_READ_WAIT: begin
                o_cmd.rd_take = 1'b1;
                n_state       = tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_SCROLL_RD: begin
                o_cmd.copy_rd = 1'b1;
                n_state       = tcw_pkg::ST_SCROLL_WR;
            end
            tcw_pkg::ST_SCROLL_WR: begin
                o_cmd.copy_wr = 1'b1;
                n_state = i_status.sweep_last ? tcw_pkg::ST_FILL : tcw_pkg::ST_SCROLL_RD;
            end
            tcw_pkg::ST_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_status.fill_last) begin
                    n_state = tcw_pkg::ST_DONE;
                end
            end
            tcw_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = tcw_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tcw_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

### hw/rtl/text_console_writer_unit.sv
// Top level of the text console writer: controller, datapath and port packing.
//
// Usage: each item on the slave stream carries an operation (put char, clear,
// cursor left/right/up/down, read cell), a character byte and a cell address.
// Every item yields exactly one result item on the master stream with the
// cursor position after the operation, the cell read back (zero unless the
// operation is a read) and a flag set when the screen scrolled.
// The attribute register is written on its own valid/ready channel, which is
// always ready; write it only while no item is in flight.
// Work per item, set by the single-port screen store and the state machine
// walking it: cursor moves, newline, backspace and printable characters go
// through the execute and done states, a read of a valid cell adds a wait
// state, a clear blanks every cell, and a put that scrolls copies each cell up
// a row with a read state and a write state per cell, then blanks the last row.
// After reset the store is filled with blanks one cell per cycle, and no item
// is accepted until the whole store is blank.
// A finished result waits in the output register while the receiver stalls;
// the next item is still accepted, and its result waits until the slot frees.
module text_console_writer_unit #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [2:0] op, [10:3] char_code, [21:11] cell_address, [23:22] zero
    input  logic [tcw_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [10:0] cursor_position, [18:11] cell_char, [26:19] cell_attr,
    // [27] scrolled, [31:28] zero
    output logic [tcw_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tcw_pkg::ATTR_W-1:0]         i_cfg_data
);

    `include "assert_macros.svh"

    tcw_pkg::t_dp_cmd            w_cmd;
    tcw_pkg::t_dp_status         w_status;
    logic [tcw_pkg::IDX_W-1:0]   w_cursor;
    logic [tcw_pkg::CHAR_W-1:0]  w_cell_char;
    logic [tcw_pkg::ATTR_W-1:0]  w_cell_attr;
    logic                        w_scrolled;

    // The attribute register takes a write in any cycle.
    assign o_cfg_ready = 1'b1;

    tcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_op        (s_axis_tdata[2:0]),
        .i_char      (s_axis_tdata[10:3]),
        .i_addr      (s_axis_tdata[21:11]),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cursor    (w_cursor),
        .o_cell_char (w_cell_char),
        .o_cell_attr (w_cell_attr),
        .o_scrolled  (w_scrolled)
    );

    assign m_axis_tdata = {4'b0000, w_scrolled, w_cell_attr, w_cell_char, w_cursor};

    // One item is worked on at a time: the block drops ready right after an accept.
    `ASSERT_NEXT(a_one_item_in_flight, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "item accepted while another is in flight")

    // A new result never overwrites one the receiver has not taken.
    `ASSERT_SAME(a_no_result_overwrite, i_clk, i_rst_n, w_cmd.load_out, !m_axis_tvalid || m_axis_tready, "result register overwritten")

    // Every copy write during a scroll uses data read in the previous cycle.
    `ASSERT_SAME(a_copy_after_read, i_clk, i_rst_n, w_cmd.copy_wr, $past(w_cmd.copy_rd), "scroll write without a preceding read")

endmodule

### test/text_console_writer_unit_tb.sv
// Self-checking testbench for the text console writer: stream stimulus, cell mirror, checks.
module text_console_writer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    // Op code 7 is unused by the block and must act as a no-op.
    localparam logic [2:0] OP_NONE = 3'd7;

    // The receiver stops once for this long after this many results, so the block backs up.
    localparam int unsigned HOLD_AFTER  = 120;
    localparam int unsigned HOLD_CYCLES = 300;
    // Idle time after the last result is in, before the next phase starts.
    localparam int unsigned SETTLE_CYCLES = 16;
    // Worst case: commands that all scroll, plus stalls, gaps, the long hold and
    // the clearing pass, taken several times over.
    localparam longint unsigned CYCLE_LIMIT = 64'd8_000_000;
    localparam int unsigned PHASE_ITEMS = 100;

    typedef struct packed {
        logic        scrolled;
        logic [7:0]  cell_attr;
        logic [7:0]  cell_char;
        logic [10:0] cursor;
    } t_console_report;

    class t_console_scoreboard;
        logic [15:0]     cells [CELLS];
        int unsigned     cursor;
        logic [7:0]      attribute;
        t_console_report expected_reports [$];
        int unsigned     checked;
        int unsigned     errors;
        int unsigned     scrolls;
        int unsigned     reads;

        function new();
            foreach (cells[i]) cells[i] = {8'h00, tcw_pkg::CH_SPACE};
            cursor    = 0;
            attribute = 8'h00;
            checked   = 0;
            errors    = 0;
            scrolls   = 0;
            reads     = 0;
        endfunction

        function void set_attribute(logic [7:0] value);
            attribute = value;
        endfunction

        // Applies one accepted command to the mirror and queues the report it must produce.
        function void note_command(logic [2:0] op, logic [7:0] ch, logic [10:0] addr);
            t_console_report rep;
            rep = '0;
            case (op)
                tcw_pkg::OP_PUT: begin
                    if (ch == tcw_pkg::CH_NEWLINE) begin
                        cursor = (cursor / COLUMNS + 1) * COLUMNS;
                    end else if (ch == tcw_pkg::CH_BACKSPACE) begin
                        if (cursor > 0) begin
                            cursor--;
                            cells[cursor] = {attribute, tcw_pkg::CH_SPACE};
                        end
                    end else begin
                        cells[cursor] = {attribute, ch};
                        cursor++;
                    end
                end
                tcw_pkg::OP_CLEAR: begin
                    foreach (cells[i]) cells[i] = {attribute, tcw_pkg::CH_SPACE};
                    cursor = 0;
                end
                tcw_pkg::OP_LEFT: begin
                    if (cursor > 0) cursor--;
                end
                tcw_pkg::OP_RIGHT: begin
                    if (cursor < CELLS - 1) cursor++;
                end
                tcw_pkg::OP_UP: begin
                    if (cursor >= COLUMNS) cursor -= COLUMNS;
                end
                tcw_pkg::OP_DOWN: begin
                    if (cursor + COLUMNS < CELLS) cursor += COLUMNS;
                end
                tcw_pkg::OP_READ: begin
                    reads++;
                    if (addr < CELLS) begin
                        rep.cell_char = cells[addr][7:0];
                        rep.cell_attr = cells[addr][15:8];
                    end
                end
                default: begin
                end
            endcase
            // Only a put can push the cursor off the screen; that scrolls one row up.
            if (cursor >= CELLS) begin
                for (int i = 0; i < CELLS - COLUMNS; i++) cells[i] = cells[i + COLUMNS];
                for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
                    cells[i] = {attribute, tcw_pkg::CH_SPACE};
                end
                cursor = CELLS - COLUMNS;
                rep.scrolled = 1'b1;
                scrolls++;
            end
            rep.cursor = 11'(cursor);
            expected_reports.push_back(rep);
        endfunction

        function void check_report(logic [31:0] word);
            t_console_report got;
            t_console_report want;
            got = word[27:0];
            checked++;
            if (expected_reports.size() == 0) begin
                $error("result item 0x%08h arrived with nothing expected", word);
                errors++;
                return;
            end
            want = expected_reports.pop_front();
            if (got.cursor != want.cursor) begin
                $error("cursor_position: expected %0d, got %0d", want.cursor, got.cursor);
                errors++;
            end
            if (got.cell_char != want.cell_char) begin
                $error("cell_char: expected 0x%02h, got 0x%02h", want.cell_char, got.cell_char);
                errors++;
            end
            if (got.cell_attr != want.cell_attr) begin
                $error("cell_attr: expected 0x%02h, got 0x%02h", want.cell_attr, got.cell_attr);
                errors++;
            end
            if (got.scrolled != want.scrolled) begin
                $error("scrolled: expected %0d, got %0d", want.scrolled, got.scrolled);
                errors++;
            end
        endfunction
    endclass

    logic                                i_clk         = 1'b0;
    logic                                i_rst_n       = 1'b0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    // [2:0] op, [10:3] char_code, [21:11] cell_address, [23:22] zero
    logic [tcw_pkg::IN_TDATA_W-1:0]      s_axis_tdata  = '0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    // [10:0] cursor_position, [18:11] cell_char, [26:19] cell_attr,
    // [27] scrolled, [31:28] zero
    logic [tcw_pkg::OUT_TDATA_W-1:0]     m_axis_tdata;
    logic                                i_cfg_valid   = 1'b0;
    logic                                o_cfg_ready;
    logic [tcw_pkg::ATTR_W-1:0]          i_cfg_data    = '0;

    t_console_scoreboard mirror = new();

    int unsigned     items_sent  = 0;
    bit              burst_phase = 1'b0;
    int unsigned     drain_pause = 0;
    int unsigned     hold_left   = 0;
    bit              hold_done   = 1'b0;
    longint unsigned cycle_count = 0;

    text_console_writer_unit #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5ns i_clk = ~i_clk;
    end

    // Watchdog: a hung block or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("text_console_writer_unit_tb: done, errors");
            $finish;
        end
    end

    // Result side. Every accepted result item is checked against the oldest
    // expectation. After each item the receiver may pause at random before it
    // is ready again (never in the burst phase); once in the run it holds off for
    // a long stretch so that the output slot and the input both fill up.
    always @(posedge i_clk) begin
        int unsigned pause;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            drain_pause   <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                mirror.check_report(m_axis_tdata);
            end
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                if (hold_left == 1) begin
                    m_axis_tready <= 1'b1;
                end
            end else if (!hold_done && mirror.checked >= HOLD_AFTER) begin
                hold_done     <= 1'b1;
                hold_left     <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else if (m_axis_tvalid && m_axis_tready) begin
                pause = burst_phase ? 0 : $urandom_range(0, 4);
                drain_pause   <= pause;
                m_axis_tready <= (pause == 0);
            end else if (!m_axis_tready) begin
                if (drain_pause <= 1) begin
                    m_axis_tready <= 1'b1;
                end else begin
                    drain_pause <= drain_pause - 1;
                end
            end
        end
    end

    // Offers one command after a random gap and returns at the edge that accepts it.
    // A valid that stays high between back-to-back items is never lowered.
    task automatic send_command(input logic [2:0] op, input logic [7:0] ch,
                                input logic [10:0] addr);
        int unsigned gap;
        gap = burst_phase ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= {2'b00, addr, ch, op};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        mirror.note_command(op, ch, addr);
        items_sent++;
    endtask

    // Stops offering and waits until every result is in and the block is quiet.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (mirror.expected_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_attribute(input logic [7:0] value);
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        mirror.set_attribute(value);
    endtask

    // Random traffic built from console-like sequences: text lines, cursor
    // wandering, readbacks, backspaces, clears, raw noise and runs to the
    // bottom edge that force both kinds of scroll.
    task automatic run_random_phase(input int unsigned quota, input bit bottom_first);
        int unsigned target;
        int unsigned kind;
        int unsigned count;
        int unsigned offset;
        int unsigned pick;
        logic [7:0]  ch;
        logic [10:0] addr;
        target = items_sent + quota;
        while (items_sent < target) begin
            kind = bottom_first ? 99 : $urandom_range(0, 99);
            bottom_first = 1'b0;
            if (kind < 40) begin
                // A line of text, mostly printable, ended by a newline most of the time.
                count = $urandom_range(1, 30);
                repeat (count) begin
                    ch = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                     : 8'($urandom_range(32, 126));
                    send_command(tcw_pkg::OP_PUT, ch, 11'($urandom_range(0, 2047)));
                end
                if ($urandom_range(0, 9) < 7) begin
                    send_command(tcw_pkg::OP_PUT, tcw_pkg::CH_NEWLINE,
                                 11'($urandom_range(0, 2047)));
                end
            end else if (kind < 55) begin
                count = $urandom_range(1, 8);
                repeat (count) begin
                    send_command(3'($urandom_range(tcw_pkg::OP_LEFT, tcw_pkg::OP_DOWN)),
                                 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
                end
            end else if (kind < 70) begin
                // Reads land mostly just behind the cursor, where text was written.
                count = $urandom_range(1, 6);
                repeat (count) begin
                    pick = $urandom_range(0, 9);
                    if (pick == 0) begin
                        addr = 11'($urandom_range(CELLS, 2047));
                    end else if (pick < 4) begin
                        addr = 11'($urandom_range(0, CELLS - 1));
                    end else begin
                        offset = $urandom_range(1, 160);
                        addr   = 11'((mirror.cursor + CELLS - offset) % CELLS);
                    end
                    send_command(tcw_pkg::OP_READ, 8'($urandom_range(0, 255)), addr);
                end
            end else if (kind < 80) begin
                count = $urandom_range(1, 5);
                repeat (count) begin
                    send_command(tcw_pkg::OP_PUT, tcw_pkg::CH_BACKSPACE,
                                 11'($urandom_range(0, 2047)));
                end
            end else if (kind < 85) begin
                send_command(tcw_pkg::OP_CLEAR, 8'($urandom_range(0, 255)),
                             11'($urandom_range(0, 2047)));
            end else if (kind < 93) begin
                send_command(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                             11'($urandom_range(0, 2047)));
            end else begin
                // Walk down to the last row (one extra down is ignored there), type
                // to the last cell, try to step past it, then write it so the screen
                // scrolls; a newline on the last row scrolls once more.
                while (mirror.cursor < CELLS - COLUMNS) begin
                    send_command(tcw_pkg::OP_DOWN, 8'($urandom_range(0, 255)),
                                 11'($urandom_range(0, 2047)));
                end
                send_command(tcw_pkg::OP_DOWN, 8'($urandom_range(0, 255)),
                             11'($urandom_range(0, 2047)));
                while (mirror.cursor != CELLS - 1) begin
                    send_command(tcw_pkg::OP_PUT, 8'($urandom_range(32, 126)),
                                 11'($urandom_range(0, 2047)));
                end
                send_command(tcw_pkg::OP_RIGHT, 8'($urandom_range(0, 255)),
                             11'($urandom_range(0, 2047)));
                send_command(tcw_pkg::OP_PUT, 8'($urandom_range(32, 126)),
                             11'($urandom_range(0, 2047)));
                send_command(tcw_pkg::OP_PUT, tcw_pkg::CH_NEWLINE,
                             11'($urandom_range(0, 2047)));
                send_command(tcw_pkg::OP_READ, 8'($urandom_range(0, 255)),
                             11'(CELLS - COLUMNS - 1));
                send_command(tcw_pkg::OP_READ, 8'($urandom_range(0, 255)), 11'(CELLS - 1));
            end
        end
    endtask

    initial begin
        logic [7:0] phase_attr;
        i_rst_n <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The block blanks its store after reset and only then takes items.
        do @(posedge i_clk); while (!s_axis_tready);
        write_attribute(8'h1F);

        // Directed part: reset contents and reads past the screen, moves and
        // backspace blocked at cell zero, character extremes, backspace blanking
        // with the attribute, newline, the unused op code and a full clear.
        send_command(tcw_pkg::OP_READ, 8'h00, 11'd0);
        send_command(tcw_pkg::OP_READ, 8'h00, 11'(CELLS - 1));
        send_command(tcw_pkg::OP_READ, 8'hFF, 11'(CELLS));
        send_command(tcw_pkg::OP_READ, 8'hFF, 11'h7FF);
        send_command(tcw_pkg::OP_PUT, tcw_pkg::CH_BACKSPACE, 11'd0);
        send_command(tcw_pkg::OP_LEFT, 8'h00, 11'd0);
        send_command(tcw_pkg::OP_UP, 8'h00, 11'd0);
        send_command(tcw_pkg::OP_PUT, 8'h41, 11'd0);
        send_command(tcw_pkg::OP_PUT, 8'hFF, 11'h7FF);
        send_command(tcw_pkg::OP_PUT, 8'h00, 11'd0);
        send_command(tcw_pkg::OP_PUT, tcw_pkg::CH_BACKSPACE, 11'd0);
        send_command(tcw_pkg::OP_PUT, tcw_pkg::CH_NEWLINE, 11'd0);
        send_command(tcw_pkg::OP_DOWN, 8'h00, 11'd0);
        send_command(tcw_pkg::OP_RIGHT, 8'h00, 11'd0);
        send_command(tcw_pkg::OP_UP, 8'h00, 11'd0);
        send_command(OP_NONE, 8'hFF, 11'h7FF);
        send_command(tcw_pkg::OP_READ, 8'h00, 11'd0);
        send_command(tcw_pkg::OP_READ, 8'h00, 11'd1);
        send_command(tcw_pkg::OP_READ, 8'h00, 11'd2);
        send_command(tcw_pkg::OP_CLEAR, 8'hFF, 11'h7FF);
        send_command(tcw_pkg::OP_READ, 8'h00, 11'(CELLS - 1));
        settle();

        // Random phases, each under its own attribute; the third runs without idling.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       phase_attr = 8'h00;
                1:       phase_attr = 8'hFF;
                default: phase_attr = 8'($urandom_range(0, 255));
            endcase
            burst_phase = (phase == 2);
            write_attribute(phase_attr);
            run_random_phase(PHASE_ITEMS, phase == 0);
            settle();
        end

        $display("Covered %0d commands and %0d results, with %0d cell reads and %0d scrolls.",
                 items_sent, mirror.checked, mirror.reads, mirror.scrolls);
        $display("Five attribute settings, a stall-free phase and one %0d-cycle output hold.",
                 HOLD_CYCLES);
        if (mirror.errors == 0) begin
            $display("text_console_writer_unit_tb: done, clean");
        end else begin
            $display("text_console_writer_unit_tb: done, errors");
        end
        $finish;
    end
endmodule
